/* hdl/rlur_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rlur_pkg
// Shared types and constants for the run-length 8N1 receiver.
// ----------------------------------------------------------------------------
package rlur_pkg;

  localparam int unsigned BIT_TIME_W = 16;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned QUO_W      = DUR_W + 1;
  localparam int unsigned DIVCNT_W   = 5;
  localparam int unsigned STEPS_W    = 5;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [BIT_TIME_W-1:0] BIT_TIME_RESET = 16'd104;
  localparam logic [COUNT_W-1:0]    CAPACITY_RESET = 11'd64;

  localparam logic [CFG_IDX_W-1:0] REG_BIT_TIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd1;

  localparam logic [POS_W-1:0] POS_IDLE = 4'd15;
  localparam logic [POS_W-1:0] POS_STOP = 4'd8;

  localparam logic [DIVCNT_W-1:0] DIV_LAST_BIT = DIVCNT_W'(QUO_W - 1);
  localparam logic [STEPS_W-1:0]  FRAME_BITS   = 5'd10;
  localparam logic [STEPS_W-1:0]  WRAP_BASE    = 5'd9;
  localparam logic [QUO_W-1:0]    WRAP_MIN     = 17'd19;
  localparam logic [3:0]          MOD_BASE     = 4'd10;
  localparam logic [3:0]          MOD_TOP      = 4'd9;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_REDUCE,
    ST_STEP,
    ST_RESULT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic reduce;
    logic bit_step;
    logic publish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
    logic steps_zero;
    logic out_free;
  } ctrl_status_t;

endpackage
`default_nettype wire

/* hdl/rlur_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rlur_ctrl
// Sequencer: accept, divide, reduce bit count, step framer, publish result.
// ----------------------------------------------------------------------------
module rlur_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    s_tvalid,
  output logic                   s_tready,
  input  rlur_pkg::ctrl_status_t status,
  output rlur_pkg::ctrl_cmd_t    cmd
);
  import rlur_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = !rst;
        if (s_tvalid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd.reduce = 1'b1;
        state_next = ST_STEP;
      end
      ST_STEP: begin
        if (status.steps_zero) begin
          state_next = ST_RESULT;
        end else begin
          cmd.bit_step = 1'b1;
        end
      end
      ST_RESULT: begin
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hdl/rlur_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rlur_dpath
// Config registers, serial divider with mod-10 tracking, 8N1 framer and
// output register.
// ----------------------------------------------------------------------------
module rlur_dpath (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire  [rlur_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [rlur_pkg::BIT_TIME_W-1:0]  cfg_data,
  input  wire                              in_level,
  input  wire  [rlur_pkg::DUR_W-1:0]       in_duration,
  input  wire                              in_last,
  input  rlur_pkg::ctrl_cmd_t              cmd,
  output rlur_pkg::ctrl_status_t           status,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic                             out_byte_valid,
  output logic [7:0]                       out_data_byte,
  output logic [rlur_pkg::COUNT_W-1:0]     out_byte_count,
  output logic                             out_buffer_done
);
  import rlur_pkg::*;

  logic [BIT_TIME_W-1:0] bit_time;
  logic [COUNT_W-1:0]    capacity;
  logic [BIT_TIME_W-1:0] bt_eff;

  logic                  level;
  logic                  last;
  logic                  zero_dur;
  logic [QUO_W-1:0]      quo;
  logic [BIT_TIME_W-1:0] rem;
  logic [3:0]            mod10;
  logic [DIVCNT_W-1:0]   div_cnt;
  logic [STEPS_W-1:0]    steps;

  logic [POS_W-1:0]      pos;
  logic [7:0]            shift_byte;
  logic [COUNT_W-1:0]    kept_count;
  logic                  byte_valid;
  logic [7:0]            data_byte;

  logic [QUO_W-1:0]      trial;
  logic                  ge;
  logic [4:0]            mod2;
  logic [3:0]            mod_plus;
  logic [STEPS_W-1:0]    steps_calc;

  assign bt_eff = (bit_time == '0) ? BIT_TIME_W'(1) : bit_time;
  assign trial  = {rem, quo[QUO_W-1]};
  assign ge     = trial >= {1'b0, bt_eff};
  assign mod2   = {mod10, ge};
  assign mod_plus = (mod10 == MOD_TOP) ? 4'd0 : mod10 + 4'd1;

  always_comb begin
    priority if (zero_dur) begin
      steps_calc = '0;
    end else if (level) begin
      steps_calc = (quo > QUO_W'(FRAME_BITS)) ? FRAME_BITS : quo[STEPS_W-1:0];
    end else if (quo >= WRAP_MIN) begin
      steps_calc = WRAP_BASE + {1'b0, mod_plus};
    end else begin
      steps_calc = quo[STEPS_W-1:0];
    end
  end

  assign status.div_last   = div_cnt == '0;
  assign status.steps_zero = steps == '0;
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_time <= BIT_TIME_RESET;
      capacity <= CAPACITY_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_BIT_TIME) begin
        bit_time <= cfg_data;
      end else if (cfg_index == REG_CAPACITY) begin
        capacity <= cfg_data[COUNT_W-1:0];
      end
    end
  end

  // divider and run bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      level    <= in_level;
      last     <= in_last;
      zero_dur <= in_duration == '0;
      quo      <= {1'b0, in_duration} + {2'b00, bt_eff[BIT_TIME_W-1:1]};
      rem      <= '0;
      mod10    <= '0;
      div_cnt  <= DIV_LAST_BIT;
    end else if (cmd.div_step) begin
      rem     <= ge ? BIT_TIME_W'(trial - {1'b0, bt_eff}) : trial[BIT_TIME_W-1:0];
      quo     <= {quo[QUO_W-2:0], ge};
      mod10   <= (mod2 >= {1'b0, MOD_BASE}) ? 4'(mod2 - {1'b0, MOD_BASE}) : mod2[3:0];
      div_cnt <= div_cnt - DIVCNT_W'(1);
    end else if (cmd.reduce) begin
      steps <= steps_calc;
    end else if (cmd.bit_step) begin
      steps <= steps - STEPS_W'(1);
    end
  end

  // framer
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= POS_IDLE;
      shift_byte <= '0;
      kept_count <= '0;
    end else if (cmd.bit_step) begin
      if (pos > POS_STOP) begin
        if (!level) begin
          pos        <= '0;
          shift_byte <= '0;
        end else begin
          pos <= POS_IDLE;
        end
      end else if (pos < POS_STOP) begin
        shift_byte[pos[2:0]] <= level;
        pos <= pos + POS_W'(1);
      end else begin
        pos <= POS_IDLE;
        if (level && kept_count < capacity) begin
          kept_count <= kept_count + COUNT_W'(1);
        end
      end
    end else if (cmd.publish && last) begin
      pos        <= POS_IDLE;
      shift_byte <= '0;
      kept_count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_valid <= 1'b0;
      data_byte  <= '0;
    end else if (cmd.bit_step && pos == POS_STOP && level && kept_count < capacity) begin
      byte_valid <= 1'b1;
      data_byte  <= shift_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_byte_valid  <= byte_valid;
      out_data_byte   <= data_byte;
      out_byte_count  <= kept_count;
      out_buffer_done <= last;
    end
  end

  frame_pos_legal: assert property (@(posedge clk) disable iff (rst)
    !(pos > POS_STOP && pos < POS_IDLE))
    else $error("framer position left its legal set");

  byte_needs_stop: assert property (@(posedge clk) disable iff (rst)
    (cmd.bit_step && !byte_valid) |=> (!byte_valid || $past(pos) == POS_STOP))
    else $error("byte kept outside a stop bit");

  steps_bounded: assert property (@(posedge clk) disable iff (rst)
    cmd.reduce |=> (steps <= WRAP_BASE + WRAP_BASE))
    else $error("reduced bit count out of range");

endmodule
`default_nettype wire

/* hdl/run_length_uart_8n1_receiver_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// run_length_uart_8n1_receiver_unit
// Converts line runs to bit counts and feeds them through an 8N1 framer.
// ----------------------------------------------------------------------------
// From input transaction to result valid: the bit-serial divider, a reduce step,
//   up to 18 framer bit steps, leaving the step loop, and publish once the
//   output register is free.
// One run at a time: the next run is accepted only after the last is published.
// Reset: synchronous; registers return to 104 us and 64 bytes, framer idle,
//   count zero, output empty. No clearing pass.
module run_length_uart_8n1_receiver_unit (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             s_tvalid,
  output logic                            s_tready,
  input  wire  [23:0]                     s_tdata,  // line_level, run_duration
  input  wire                             s_tlast,  // last_run
  output logic                            m_tvalid,
  input  wire                             m_tready,
  output logic [23:0]                     m_tdata,  // data_byte, byte_count
  output logic [0:0]                      m_tuser,  // byte_valid
  output logic                            m_tlast,  // buffer_done
  input  wire                             cfg_we,
  input  wire  [rlur_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [rlur_pkg::BIT_TIME_W-1:0] cfg_data
);
  import rlur_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;
  logic         byte_valid;
  logic [7:0]   data_byte;
  logic [COUNT_W-1:0] byte_count;

  rlur_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rlur_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_level        (s_tdata[0]),
    .in_duration     (s_tdata[DUR_W:1]),
    .in_last         (s_tlast),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_byte_valid  (byte_valid),
    .out_data_byte   (data_byte),
    .out_byte_count  (byte_count),
    .out_buffer_done (m_tlast)
  );

  assign m_tdata = {5'b0, byte_count, data_byte};
  assign m_tuser = byte_valid;

  no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second run accepted while one is in work");

  kept_byte_counted: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[18:8] != '0))
    else $error("kept byte reported with zero count");

  empty_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[7:0] == '0))
    else $error("data byte nonzero without a kept byte");

endmodule
`default_nettype wire
